// ----- rtl/fdp_pkg.sv -----
// Shared types, constants and helper functions for the float dot product unit.
// Used by fdp_fma, fdp_tree and float_dot_product_16_lane_unit.
package fdp_pkg;

   // Lane count must stay a power of two above the multiply-add depth (8).
   localparam int LANES       = 16;
   localparam int LANE_BITS   = $clog2(LANES);
   localparam int TREE_LEVELS = $clog2(LANES);

   // Single-precision bit patterns.
   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
   localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;

   // Wide signed exponent used inside the multiply-add.
   typedef logic signed [11:0] exp_type;

   // Sideband that travels with a request through the multiply-add.
   typedef struct packed {
      logic [LANE_BITS-1:0] lane;
      logic                 last;
   } fdp_tag_type;

   // Index of the highest set bit (zero for a zero word).
   function automatic logic [5:0] msb64(input logic [63:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 1; i < 64; i++) begin
         if (v[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

endpackage

// ----- rtl/float_dot_product_16_lane_unit.sv -----
// Streaming single-precision dot product: 16 lane accumulators and a reduction tree.
// Depends on fdp_pkg, fdp_fma and fdp_tree.
//
// Usage:
//  - The request channel (req_valid, req_stall) carries one pair of IEEE single
//    values per request plus req_last_element. Request k of a vector goes to
//    lane k mod 16, where a fused multiply-add updates that lane's sum.
//  - A request with req_last_element set closes the vector: the 16 lane sums go
//    through a four-level adder tree and the total leaves on the response
//    channel (rsp_valid, rsp_stall, rsp_dot_result). Other requests give none.
//  - Throughput is one request per cycle unless stalled. The eight-stage
//    multiply-add writes a lane well before it is read again 16 requests on.
//  - The closing request passes 41 registers on its way to rsp_valid: 8 of
//    multiply-add, 32 of tree and 1 output register, the first of them loaded
//    at the accepting edge.
//  - Reset clears the lane position, the lane valid bits and all pipeline
//    valids; lane sums then read as +0.
//  - When rsp_stall holds a waiting response, the pipeline keeps moving until a
//    second response reaches the tree output; only then does it freeze and
//    raise req_stall. Nothing is dropped or repeated.
module float_dot_product_16_lane_unit import fdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_left_value,
   input  logic [31:0] req_right_value,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_dot_result
);

   logic              advance;
   logic              accept;
   logic              fma_valid;
   fdp_tag_type       fma_tag;
   logic [31:0]       fma_result;
   logic              tree_valid;
   logic [31:0]       tree_sum;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_data_ff;
   logic [LANE_BITS-1:0] pos_ff, pos_in;
   logic [LANE_BITS:0]   count_ff, count_in;
   logic [31:0]       lane_sum_ff [LANES];
   logic [LANES-1:0]  lane_valid_ff;
   logic [31:0]       addend;
   logic [31:0]       snap [LANES];
   logic              wb;
   fdp_tag_type       req_tag;

   // The whole pipeline moves unless a second response would collide.
   assign advance   = !(tree_valid && rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // Lane position and count of requests in the current vector.
   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_last_element) begin
            pos_in   = '0;
            count_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (count_ff != (LANE_BITS+1)'(LANES)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   // The first 16 requests of a vector start from zero.
   assign addend = (count_ff < (LANE_BITS+1)'(LANES)) ? 32'd0 : lane_sum_ff[pos_ff];
   assign req_tag.lane = pos_ff;
   assign req_tag.last = req_last_element;

   fdp_fma u_lane_fma (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (req_valid),
      .in_tag    (req_tag),
      .a         (req_left_value),
      .b         (req_right_value),
      .c         (addend),
      .out_valid (fma_valid),
      .out_tag   (fma_tag),
      .result    (fma_result)
   );

   // Write back the lane sum; the closing request clears the lane valid bits.
   assign wb = advance && fma_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= '0;
      end else if (wb) begin
         if (fma_tag.last) begin
            lane_valid_ff <= '0;
         end else begin
            lane_valid_ff[fma_tag.lane] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wb) begin
         lane_sum_ff[fma_tag.lane] <= fma_result;
      end
   end

   // Snapshot of all lanes, including the closing request's fresh sum.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (fma_tag.lane == LANE_BITS'(i)) begin
            snap[i] = fma_result;
         end else if (lane_valid_ff[i]) begin
            snap[i] = lane_sum_ff[i];
         end else begin
            snap[i] = 32'd0;
         end
      end
   end

   fdp_tree u_tree (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (fma_valid && fma_tag.last),
      .in_lanes  (snap),
      .out_valid (tree_valid),
      .out_sum   (tree_sum)
   );

   // Output register between the tree and the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && tree_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tree_valid) begin
         rsp_data_ff <= tree_sum;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dot_result = rsp_data_ff;

endmodule

// ----- rtl/fdp_fma.sv -----
// Eight-stage single-precision fused multiply-add, round to nearest even.
// Depends on fdp_pkg for constants, the exponent type and the sideband tag.
module fdp_fma import fdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  fdp_tag_type in_tag,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [31:0] c,
   output logic        out_valid,
   output fdp_tag_type out_tag,
   output logic [31:0] result
);

   localparam int STAGES = 8;

   // Valid and tag chains that move with the data.
   logic [STAGES-1:0] vld_ff;
   fdp_tag_type       tag_ff [STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int i = 1; i < STAGES; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];

   // Stage 1: classify operands, unpack, multiply the significands.
   logic        sp_in;
   logic [30:0] ma, mb, mc;
   logic [23:0] xa, xb, xc;
   exp_type     ea, eb, ec;
   logic        direct_in;
   logic [31:0] dval_in;

   assign sp_in = a[31] ^ b[31];
   assign ma = a[30:0];
   assign mb = b[30:0];
   assign mc = c[30:0];
   assign xa = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
   assign xb = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
   assign xc = (c[30:23] == 8'd0) ? {1'b0, c[22:0]} : {1'b1, c[22:0]};
   assign ea = (a[30:23] == 8'd0) ? exp_type'(-149) : exp_type'({4'd0, a[30:23]}) - exp_type'(150);
   assign eb = (b[30:23] == 8'd0) ? exp_type'(-149) : exp_type'({4'd0, b[30:23]}) - exp_type'(150);
   assign ec = (c[30:23] == 8'd0) ? exp_type'(-149) : exp_type'({4'd0, c[30:23]}) - exp_type'(150);

   // NaN, infinity and zero-product cases resolve without rounding.
   always_comb begin
      direct_in = 1'b1;
      dval_in   = '0;
      if (ma > INF_BITS[30:0] || mb > INF_BITS[30:0] || mc > INF_BITS[30:0]) begin
         dval_in = QNAN_BITS;
      end else if (ma == INF_BITS[30:0] || mb == INF_BITS[30:0]) begin
         if (ma == 31'd0 || mb == 31'd0) begin
            dval_in = QNAN_BITS;
         end else if (mc == INF_BITS[30:0] && c[31] != sp_in) begin
            dval_in = QNAN_BITS;
         end else begin
            dval_in = {sp_in, INF_BITS[30:0]};
         end
      end else if (mc == INF_BITS[30:0]) begin
         dval_in = c;
      end else if ((ma == 31'd0 || mb == 31'd0) && mc == 31'd0) begin
         dval_in = (sp_in == c[31]) ? {sp_in, 31'd0} : 32'd0;
      end else if (ma == 31'd0 || mb == 31'd0) begin
         dval_in = c;
      end else begin
         direct_in = 1'b0;
      end
   end

   logic [47:0] s1_prod_ff;
   exp_type     s1_ep_ff, s1_ec_ff;
   logic [23:0] s1_cm_ff;
   logic        s1_sp_ff, s1_sc_ff, s1_cz_ff, s1_direct_ff;
   logic [31:0] s1_dval_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff   <= xa * xb;
         s1_ep_ff     <= ea + eb;
         s1_cm_ff     <= xc;
         s1_ec_ff     <= ec;
         s1_sp_ff     <= sp_in;
         s1_sc_ff     <= c[31];
         s1_cz_ff     <= (mc == 31'd0);
         s1_direct_ff <= direct_in;
         s1_dval_ff   <= dval_in;
      end
   end

   // Stage 2: find leading ones and the normalized exponents.
   logic [5:0] lp_in, lc_in;

   assign lp_in = 6'd61 - msb64({16'd0, s1_prod_ff});
   assign lc_in = 6'd61 - msb64({40'd0, s1_cm_ff});

   logic [47:0] s2_prod_ff;
   logic [23:0] s2_cm_ff;
   logic [5:0]  s2_lp_ff, s2_lc_ff;
   exp_type     s2_ep_ff, s2_ec_ff;
   logic        s2_sp_ff, s2_sc_ff, s2_cz_ff, s2_direct_ff;
   logic [31:0] s2_dval_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_prod_ff   <= s1_prod_ff;
         s2_cm_ff     <= s1_cm_ff;
         s2_lp_ff     <= lp_in;
         s2_lc_ff     <= lc_in;
         s2_ep_ff     <= s1_ep_ff - exp_type'({6'd0, lp_in});
         s2_ec_ff     <= s1_ec_ff - exp_type'({6'd0, lc_in});
         s2_sp_ff     <= s1_sp_ff;
         s2_sc_ff     <= s1_sc_ff;
         s2_cz_ff     <= s1_cz_ff;
         s2_direct_ff <= s1_direct_ff;
         s2_dval_ff   <= s1_dval_ff;
      end
   end

   // Stage 3: shift both operands so their leading one sits at bit 61.
   logic [63:0] s3_xp_ff, s3_xc_ff;
   exp_type     s3_ep_ff, s3_ec_ff;
   logic        s3_sp_ff, s3_sc_ff, s3_cz_ff, s3_direct_ff;
   logic [31:0] s3_dval_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_xp_ff     <= {16'd0, s2_prod_ff} << s2_lp_ff;
         s3_xc_ff     <= {40'd0, s2_cm_ff} << s2_lc_ff;
         s3_ep_ff     <= s2_ep_ff;
         s3_ec_ff     <= s2_ec_ff;
         s3_sp_ff     <= s2_sp_ff;
         s3_sc_ff     <= s2_sc_ff;
         s3_cz_ff     <= s2_cz_ff;
         s3_direct_ff <= s2_direct_ff;
         s3_dval_ff   <= s2_dval_ff;
      end
   end

   // Stage 4: order by exponent and align the smaller operand with sticky.
   logic        psel;
   logic [63:0] x_in, y_raw, y_in, ymask;
   exp_type     ex_in, ey, d;
   logic        sx_in, sy_in;

   always_comb begin
      psel  = s3_cz_ff || (s3_ep_ff >= s3_ec_ff);
      x_in  = psel ? s3_xp_ff : s3_xc_ff;
      y_raw = psel ? s3_xc_ff : s3_xp_ff;
      ex_in = psel ? s3_ep_ff : s3_ec_ff;
      ey    = psel ? s3_ec_ff : s3_ep_ff;
      sx_in = psel ? s3_sp_ff : s3_sc_ff;
      sy_in = psel ? s3_sc_ff : s3_sp_ff;
      d     = ex_in - ey;
      ymask = (64'd1 << d[5:0]) - 64'd1;
      if (s3_cz_ff) begin
         y_in = '0;
      end else if (d >= exp_type'(62)) begin
         y_in = 64'd1;
      end else begin
         y_in = (y_raw >> d[5:0]) | {63'd0, |(y_raw & ymask)};
      end
   end

   logic [63:0] s4_x_ff, s4_y_ff;
   exp_type     s4_ex_ff;
   logic        s4_sx_ff, s4_sy_ff, s4_direct_ff;
   logic [31:0] s4_dval_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_x_ff      <= x_in;
         s4_y_ff      <= y_in;
         s4_ex_ff     <= ex_in;
         s4_sx_ff     <= sx_in;
         s4_sy_ff     <= sy_in;
         s4_direct_ff <= s3_direct_ff;
         s4_dval_ff   <= s3_dval_ff;
      end
   end

   // Stage 5: add or subtract magnitudes.
   logic [63:0] r_in;
   logic        sr_in;

   always_comb begin
      if (s4_sx_ff == s4_sy_ff) begin
         r_in  = s4_x_ff + s4_y_ff;
         sr_in = s4_sx_ff;
      end else if (s4_x_ff >= s4_y_ff) begin
         r_in  = s4_x_ff - s4_y_ff;
         sr_in = s4_sx_ff;
      end else begin
         r_in  = s4_y_ff - s4_x_ff;
         sr_in = s4_sy_ff;
      end
   end

   logic [63:0] s5_r_ff;
   exp_type     s5_ex_ff;
   logic        s5_sr_ff, s5_direct_ff;
   logic [31:0] s5_dval_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s5_r_ff      <= r_in;
         s5_ex_ff     <= s4_ex_ff;
         s5_sr_ff     <= sr_in;
         s5_direct_ff <= s4_direct_ff;
         s5_dval_ff   <= s4_dval_ff;
      end
   end

   // Stage 6: rounding position, clamped at the subnormal floor.
   exp_type sh_in;

   always_comb begin
      sh_in = exp_type'({6'd0, msb64(s5_r_ff)}) - exp_type'(23);
      if (s5_ex_ff + sh_in < exp_type'(-149)) begin
         sh_in = exp_type'(-149) - s5_ex_ff;
      end
   end

   logic [63:0] s6_r_ff;
   exp_type     s6_sh_ff, s6_ex_ff;
   logic        s6_sr_ff, s6_rz_ff, s6_direct_ff;
   logic [31:0] s6_dval_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s6_r_ff      <= s5_r_ff;
         s6_sh_ff     <= sh_in;
         s6_ex_ff     <= s5_ex_ff;
         s6_sr_ff     <= s5_sr_ff;
         s6_rz_ff     <= (s5_r_ff == 64'd0);
         s6_direct_ff <= s5_direct_ff;
         s6_dval_ff   <= s5_dval_ff;
      end
   end

   // Stage 7: cut the significand and decide the round-up.
   logic [23:0] mant_in;
   logic        ru_in;
   logic [63:0] shr, lmask, shl;
   logic [5:0]  s_amt, nsh;

   always_comb begin
      s_amt   = s6_sh_ff[5:0];
      nsh     = 6'd0 - s6_sh_ff[5:0];
      shr     = s6_r_ff >> s_amt;
      shl     = s6_r_ff << nsh;
      lmask   = (64'd1 << (s_amt - 6'd1)) - 64'd1;
      mant_in = '0;
      ru_in   = 1'b0;
      if (s6_sh_ff <= exp_type'(0)) begin
         mant_in = shl[23:0];
      end else if (s6_sh_ff <= exp_type'(62)) begin
         mant_in = shr[23:0];
         ru_in   = s6_r_ff[s_amt - 6'd1] && ((|(s6_r_ff & lmask)) || shr[0]);
      end
   end

   logic [23:0] s7_mant_ff;
   logic        s7_ru_ff, s7_sr_ff, s7_rz_ff, s7_direct_ff;
   exp_type     s7_lsb_ff;
   logic [31:0] s7_dval_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s7_mant_ff   <= mant_in;
         s7_ru_ff     <= ru_in;
         s7_lsb_ff    <= s6_ex_ff + s6_sh_ff;
         s7_sr_ff     <= s6_sr_ff;
         s7_rz_ff     <= s6_rz_ff;
         s7_direct_ff <= s6_direct_ff;
         s7_dval_ff   <= s6_dval_ff;
      end
   end

   // Stage 8: round, pack, saturate to infinity, pick the final value.
   logic [24:0] m_rnd;
   exp_type     biased;
   logic [39:0] packed_bits;
   logic [31:0] res_in;

   always_comb begin
      m_rnd       = {1'b0, s7_mant_ff} + {24'd0, s7_ru_ff};
      biased      = s7_lsb_ff + exp_type'(149);
      packed_bits = ({28'd0, biased} << 23) + {15'd0, m_rnd};
      if (packed_bits >= {8'd0, INF_BITS}) begin
         packed_bits = {8'd0, INF_BITS};
      end
      if (s7_direct_ff) begin
         res_in = s7_dval_ff;
      end else if (s7_rz_ff) begin
         res_in = 32'd0;
      end else begin
         res_in = {s7_sr_ff, packed_bits[30:0]};
      end
   end

   logic [31:0] result_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= res_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- rtl/fdp_tree.sv -----
// Pipelined halving adder tree that reduces all lane sums to one value.
// Depends on fdp_pkg and on fdp_fma, used as an adder with a unit multiplier.
module fdp_tree import fdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] in_lanes [LANES],
   output logic        out_valid,
   output logic [31:0] out_sum
);

   logic [31:0] node [TREE_LEVELS+1][LANES];
   logic        lvl_valid [TREE_LEVELS+1];

   // Level zero is the lane snapshot.
   assign lvl_valid[0] = in_valid;
   for (genvar i = 0; i < LANES; i++) begin : g_leaf
      assign node[0][i] = in_lanes[i];
   end

   // Each level adds entry i and entry i plus half.
   for (genvar l = 0; l < TREE_LEVELS; l++) begin : g_level
      localparam int HALF = LANES >> (l + 1);
      for (genvar i = 0; i < LANES; i++) begin : g_node
         if (i == 0) begin : g_first
            fdp_fma u_add (
               .clock     (clock),
               .reset     (reset),
               .en        (en),
               .in_valid  (lvl_valid[l]),
               .in_tag    ('0),
               .a         (node[l][i]),
               .b         (ONE_BITS),
               .c         (node[l][i+HALF]),
               .out_valid (lvl_valid[l+1]),
               .out_tag   (),
               .result    (node[l+1][i])
            );
         end else if (i < HALF) begin : g_add
            fdp_fma u_add (
               .clock     (clock),
               .reset     (reset),
               .en        (en),
               .in_valid  (lvl_valid[l]),
               .in_tag    ('0),
               .a         (node[l][i]),
               .b         (ONE_BITS),
               .c         (node[l][i+HALF]),
               .out_valid (),
               .out_tag   (),
               .result    (node[l+1][i])
            );
         end else begin : g_idle
            assign node[l+1][i] = '0;
         end
      end
   end

   assign out_valid = lvl_valid[TREE_LEVELS];
   assign out_sum   = node[TREE_LEVELS][0];

endmodule

// ----- bench/fdp_checker.sv -----
// Checker for the float dot product unit: watches both channels, predicts each result.
// Depends on fdp_pkg for the lane count and the special bit patterns.
`timescale 1ns / 1ps

module fdp_checker import fdp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_left_value,
   input  logic [31:0] req_right_value,
   input  logic        req_last_element,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_dot_result,
   output int          error_count,
   output int          pending_count
);

   // Predicted lane sums, the next lane, and the totals still to arrive.
   logic [31:0] lane_acc [LANES];
   int unsigned next_lane;
   logic [31:0] dot_expect_q [$];

   // Highest set bit of a 64-bit magnitude.
   function automatic int top_bit(input logic [63:0] v);
      int p;
      p = 0;
      for (int i = 1; i < 64; i++) begin
         if (v[i]) begin
            p = i;
         end
      end
      return p;
   endfunction

   // Magnitude and exponent of the lowest mantissa bit.
   function automatic void split_float(input logic [31:0] f, output logic [63:0] m,
                                       output int e);
      if (f[30:23] == 8'd0) begin
         m = {41'd0, f[22:0]};
         e = -149;
      end else begin
         m = {40'd0, 1'b1, f[22:0]};
         e = int'(f[30:23]) - 150;
      end
   endfunction

   // Rounds sign * r * 2^e to single precision, nearest even, with gradual underflow.
   function automatic logic [31:0] round_to_single(input logic s, input logic [63:0] r,
                                                   input int e);
      int sh;
      logic [63:0] mant, rem, half;
      longint expo;
      logic [63:0] packed_bits;
      sh = top_bit(r) - 23;
      if (e + sh < -149) begin
         sh = -149 - e;
      end
      if (sh <= 0) begin
         mant = r << (-sh);
      end else if (sh > 62) begin
         mant = '0;
      end else begin
         rem  = r & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         mant = r >> sh;
         if (rem > half || (rem == half && mant[0])) begin
            mant = mant + 64'd1;
         end
      end
      expo = longint'(e) + sh + 149;
      packed_bits = (64'(expo) << 23) + mant;
      if (packed_bits >= 64'(INF_BITS)) begin
         packed_bits = 64'(INF_BITS);
      end
      return {s, packed_bits[30:0]};
   endfunction

   // a * b + c with a single rounding.
   function automatic logic [31:0] fused_madd(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] c);
      logic sp, sc, sx, sy, sr;
      logic [31:0] ma, mb, mc;
      logic [63:0] xa, xb, xc, xp, x, y, r;
      int ea, eb, ec, ep, ex, ey, d, q;
      sp = a[31] ^ b[31];
      sc = c[31];
      ma = {1'b0, a[30:0]};
      mb = {1'b0, b[30:0]};
      mc = {1'b0, c[30:0]};
      if (ma > INF_BITS || mb > INF_BITS || mc > INF_BITS) begin
         return QNAN_BITS;
      end
      if (ma == INF_BITS || mb == INF_BITS) begin
         if (ma == 0 || mb == 0) begin
            return QNAN_BITS;
         end
         if (mc == INF_BITS && sc != sp) begin
            return QNAN_BITS;
         end
         return {sp, INF_BITS[30:0]};
      end
      if (mc == INF_BITS) begin
         return c;
      end
      split_float(a, xa, ea);
      split_float(b, xb, eb);
      split_float(c, xc, ec);
      xp = xa * xb;
      ep = ea + eb;
      if (xp == 0 && xc == 0) begin
         return (sp == sc) ? {sp, 31'd0} : 32'd0;
      end
      if (xp == 0) begin
         return c;
      end
      if (xc == 0) begin
         return round_to_single(sp, xp, ep);
      end
      // Align both terms to bit 61 before the add.
      q  = top_bit(xp);
      xp = xp << (61 - q);
      ep = ep - (61 - q);
      q  = top_bit(xc);
      xc = xc << (61 - q);
      ec = ec - (61 - q);
      if (ep >= ec) begin
         x = xp; ex = ep; sx = sp; y = xc; ey = ec; sy = sc;
      end else begin
         x = xc; ex = ec; sx = sc; y = xp; ey = ep; sy = sp;
      end
      d = ex - ey;
      if (d >= 62) begin
         y = 64'd1;
      end else if (d > 0) begin
         y = (y >> d) | {63'd0, (y & ((64'd1 << d) - 64'd1)) != 0};
      end
      if (sx == sy) begin
         r = x + y;
         sr = sx;
      end else if (x >= y) begin
         r = x - y;
         sr = sx;
      end else begin
         r = y - x;
         sr = sy;
      end
      if (r == 0) begin
         return 32'd0;
      end
      return round_to_single(sr, r, ex);
   endfunction

   // Halving-tree reduction of the lane sums.
   function automatic logic [31:0] reduce_lanes(input logic [31:0] sums [LANES]);
      logic [31:0] t [LANES];
      int cnt, h;
      t = sums;
      cnt = LANES;
      while (cnt > 1) begin
         h = (cnt + 1) / 2;
         for (int i = 0; i + h < cnt; i++) begin
            t[i] = fused_madd(t[i], ONE_BITS, t[i + h]);
         end
         cnt = h;
      end
      return t[0];
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("fdp_checker: %s got %08h expected %08h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   // Both channels are sampled at the edge, before the new drive values settle.
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            lane_acc[i] = 32'd0;
         end
         next_lane = 0;
         dot_expect_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            lane_acc[next_lane] = fused_madd(req_left_value, req_right_value,
                                             lane_acc[next_lane]);
            next_lane = (next_lane + 1) % LANES;
            if (req_last_element) begin
               dot_expect_q.push_back(reduce_lanes(lane_acc));
               for (int i = 0; i < LANES; i++) begin
                  lane_acc[i] = 32'd0;
               end
               next_lane = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (dot_expect_q.size() == 0) begin
               report_mismatch("unexpected dot result", rsp_dot_result, 32'd0);
            end else begin
               want = dot_expect_q.pop_front();
               if (rsp_dot_result !== want) begin
                  report_mismatch("dot_result", rsp_dot_result, want);
               end
            end
         end
      end
      pending_count = dot_expect_q.size();
   end

endmodule

// ----- bench/tb_top.sv -----
// Top of the float dot product bench: clock, reset, request stimulus and response stalls.
// Depends on fdp_pkg, float_dot_product_16_lane_unit and fdp_checker.
`timescale 1ns / 1ps

module tb_top import fdp_pkg::*;;

   localparam int RANDOM_ITEMS = 1450;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_left_value;
   logic [31:0] req_right_value;
   logic        req_last_element;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_dot_result;
   int          error_count;
   int          pending_count;
   int          cycle_count;

   // Idle and stall rates in percent for the current phase.
   int          send_idle_pct;
   int          stall_pct;
   bit          hold_request;

   float_dot_product_16_lane_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_left_value(req_left_value), .req_right_value(req_right_value),
      .req_last_element(req_last_element),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_dot_result(rsp_dot_result)
   );

   fdp_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_left_value(req_left_value), .req_right_value(req_right_value),
      .req_last_element(req_last_element),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_dot_result(rsp_dot_result),
      .error_count(error_count), .pending_count(pending_count)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Watchdog on the whole run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Response side: random stalls, or one long hold-off when asked for.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Element values: mostly moderate numbers, some raw patterns, a few specials.
   function automatic logic [31:0] pick_value();
      int k;
      k = $urandom_range(0, 99);
      if (k < 80) begin
         return {1'($urandom), 8'($urandom_range(110, 145)), 23'($urandom)};
      end else if (k < 96) begin
         return $urandom;
      end
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return INF_BITS;
         3: return {1'b1, INF_BITS[30:0]};
         4: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
         5: return {1'($urandom), 8'h00, 23'($urandom)};
         6: return {1'($urandom), 31'h7F7F_FFFF};
         default: return {1'($urandom), 31'h0080_0000};
      endcase
   endfunction

   // Offers one request and holds it until it is taken.
   task automatic send_pair(input logic [31:0] l, input logic [31:0] r, input logic last);
      req_valid        <= 1'b1;
      req_left_value   <= l;
      req_right_value  <= r;
      req_last_element <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic maybe_idle();
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   initial begin
      int sent, len, phase, timeout;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_left_value   <= 32'd0;
      req_right_value  <= 32'd0;
      req_last_element <= 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zeros, signed zeros, invalid products, overflow, subnormals, cancellation.
      send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
      send_pair(32'h8000_0000, 32'h0000_0000, 1'b1);
      send_pair(32'h8000_0000, 32'h8000_0001, 1'b1);
      send_pair(INF_BITS, 32'h0000_0000, 1'b1);
      send_pair(QNAN_BITS, ONE_BITS, 1'b1);
      send_pair(INF_BITS, ONE_BITS, 1'b0);
      send_pair({1'b1, INF_BITS[30:0]}, ONE_BITS, 1'b1);
      send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1);
      send_pair(32'h0000_0001, ONE_BITS, 1'b1);
      send_pair(32'h0000_0001, 32'h3F00_0000, 1'b1);
      send_pair(ONE_BITS, ONE_BITS, 1'b0);
      send_pair(32'hBF80_0000, ONE_BITS, 1'b1);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_pair(32'h7F7F_FFFF, 32'h4000_0000, 1'b0);
      send_pair(32'hFF7F_FFFF, 32'h4000_0000, 1'b1);
      for (int i = 0; i < 17; i++) begin
         send_pair(ONE_BITS, 32'h3F80_0000 + i, i == 16);
      end

      // The first random vectors always meet one long receiver hold-off.
      hold_request = 1'b1;

      // Random vectors; the idling phase changes every few vectors.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0) begin
            phase = (phase + 1) % 5;
            case (phase)
               0: begin send_idle_pct = 0;  stall_pct = 0;  end
               1: begin send_idle_pct = 68; stall_pct = 0;  end
               2: begin send_idle_pct = 0;  stall_pct = 68; end
               3: begin send_idle_pct = 11; stall_pct = 11; end
               default: begin send_idle_pct = 0; stall_pct = 0; hold_request = 1'b1; end
            endcase
         end
         if (phase == 4) begin
            len = $urandom_range(1, 3);
         end else if ($urandom_range(0, 9) < 8) begin
            len = $urandom_range(1, 40);
         end else begin
            len = $urandom_range(41, 100);
         end
         for (int i = 0; i < len; i++) begin
            send_pair(pick_value(), pick_value(), i == len - 1);
            sent++;
            maybe_idle();
         end
      end
      req_valid <= 1'b0;
      stall_pct = 0;

      // Drain everything that is still on its way.
      timeout = 0;
      while (pending_count != 0 && timeout < 20000) begin
         @(posedge clock);
         timeout++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/fdp_pkg.sv
rtl/fdp_fma.sv
rtl/fdp_tree.sv
rtl/float_dot_product_16_lane_unit.sv
bench/fdp_checker.sv
bench/tb_top.sv
